// File: rtl/efe_pkg.sv
// shared types, constants and helpers for the escaped frame encoder
package efe_pkg;

  localparam int MaxRun = 6;
  localparam int CntW = $clog2(MaxRun + 1);

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] XON_BYTE  = 8'h11;
  localparam logic [7:0] XOFF_BYTE = 8'h13;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] SUM_BASE  = 8'hFF;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_DATA  = 1'b1
  } req_kind_t;

  // one input item as seen by the builder
  typedef struct packed {
    logic       req_type;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } req_t;

  // run of line bytes caused by one item
  typedef struct packed {
    logic [MaxRun-1:0][7:0] seq;
    logic [CntW-1:0]        cnt;
    logic                   has_end;
  } burst_t;

  // escaped form of one byte
  typedef struct packed {
    logic       two;
    logic [7:0] first;
    logic [7:0] second;
  } esc_t;

  function automatic esc_t escape(input logic [7:0] b);
    esc_t e;
    e.second = b ^ ESC_XOR;
    if (b == FLAG_BYTE || b == ESC_BYTE || b == XON_BYTE || b == XOFF_BYTE) begin
      e.two   = 1'b1;
      e.first = ESC_BYTE;
    end else begin
      e.two   = 1'b0;
      e.first = b;
    end
    return e;
  endfunction

endpackage

// File: rtl/efe_if.sv
// valid/ready channel interfaces for request items and line bytes
interface efe_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] command_code;
  logic [7:0] payload_length;
  logic [7:0] data_byte;

  modport source (output valid, req_type, command_code, payload_length, data_byte,
                  input ready);
  modport sink   (input valid, req_type, command_code, payload_length, data_byte,
                  output ready);
endinterface

interface efe_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, line_byte, frame_end, run_last, input ready);
  modport sink   (input valid, line_byte, frame_end, run_last, output ready);
endinterface

// File: rtl/efe_build.sv
// frame state and per-item byte run construction
module efe_build (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  efe_pkg::req_t req,
  output efe_pkg::burst_t burst
);
  import efe_pkg::*;

  logic [7:0] sum_acc;
  logic [7:0] bytes_left;
  logic       frame_open;
  logic [7:0] sum_acc_next;
  logic [7:0] bytes_left_next;
  logic       frame_open_next;

  always_comb begin
    logic [7:0]      len1;
    logic [7:0]      chk;
    logic [CntW-1:0] n;
    esc_t            e;
    logic            close;

    sum_acc_next    = sum_acc;
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    burst.seq       = '0;
    n               = '0;
    close           = 1'b0;
    len1            = req.payload_length + 8'd1;

    if (req.req_type == REQ_START) begin
      burst.seq[n] = FLAG_BYTE;
      n = n + 1'b1;
      e = escape(len1);
      burst.seq[n] = e.first;
      n = n + 1'b1;
      if (e.two) begin
        burst.seq[n] = e.second;
        n = n + 1'b1;
      end
      burst.seq[n] = req.command_code;
      n = n + 1'b1;
      sum_acc_next    = req.command_code;
      bytes_left_next = req.payload_length;
      frame_open_next = 1'b1;
      close           = (req.payload_length == 8'd0);
    end else if (frame_open) begin
      e = escape(req.data_byte);
      burst.seq[n] = e.first;
      n = n + 1'b1;
      if (e.two) begin
        burst.seq[n] = e.second;
        n = n + 1'b1;
      end
      sum_acc_next    = sum_acc + req.data_byte;
      bytes_left_next = bytes_left - 8'd1;
      close           = (bytes_left_next == 8'd0);
    end

    // checksum closes the frame
    chk = SUM_BASE - sum_acc_next;
    e   = escape(chk);
    if (close) begin
      burst.seq[n] = e.first;
      n = n + 1'b1;
      if (e.two) begin
        burst.seq[n] = e.second;
        n = n + 1'b1;
      end
      frame_open_next = 1'b0;
      bytes_left_next = 8'd0;
    end

    burst.cnt     = n;
    burst.has_end = close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc    <= '0;
      bytes_left <= '0;
      frame_open <= 1'b0;
    end else if (accept) begin
      sum_acc    <= sum_acc_next;
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
    end
  end

endmodule

// File: rtl/efe_ser.sv
// result register that drains a byte run one line byte per cycle while the receiver is ready
module efe_ser (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  efe_pkg::burst_t burst,
  output logic            can_load,
  efe_line_if.source      line_ch
);
  import efe_pkg::*;

  logic [MaxRun-1:0][7:0] seq;
  logic [CntW-1:0]        left;
  logic                   has_end;
  logic                   take;
  logic                   last;

  assign last              = (left == CntW'(1));
  assign take              = line_ch.valid && line_ch.ready;
  assign can_load          = (left == '0) || (last && line_ch.ready);
  assign line_ch.valid     = (left != '0);
  assign line_ch.line_byte = seq[0];
  assign line_ch.run_last  = last;
  assign line_ch.frame_end = last && has_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load && burst.cnt != '0) begin
      left <= burst.cnt;
    end else if (take) begin
      left <= left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && burst.cnt != '0) begin
      seq     <= burst.seq;
      has_end <= burst.has_end;
    end else if (take) begin
      seq <= {8'h00, seq[MaxRun-1:1]};
    end
  end

endmodule

// File: rtl/escaped_frame_encoder.sv
// escaped frame encoder: item in, run of zero to six stuffed line bytes out
// latency: the first line byte of an item is valid the cycle after it is accepted
// hand-over: an item yielding k line bytes (k from 1 to 6) holds the output register until
//   its last byte is taken; the next item is taken in the cycle its predecessor's last
//   byte leaves, so items follow back to back, paced by the one-byte output port
// reset: synchronous, clears the checksum, the byte count, the open-frame flag and the result register
module escaped_frame_encoder (
  input  logic      clk,
  input  logic      rst,
  efe_req_if.sink   req_ch,
  efe_line_if.source line_ch
);
  import efe_pkg::*;

  req_t   req;
  burst_t burst;
  logic   can_load;
  logic   accept;

  // input item gathered into one struct for the builder
  assign req.req_type       = req_ch.req_type;
  assign req.command_code   = req_ch.command_code;
  assign req.payload_length = req_ch.payload_length;
  assign req.data_byte      = req_ch.data_byte;

  // ready whenever the result register is empty or about to hand over its last byte
  assign req_ch.ready = can_load;
  assign accept       = req_ch.valid && can_load;

  // frame state plus the combinational build of the byte run
  efe_build u_build (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .burst  (burst)
  );

  // result register and byte-wise drain; empty runs (stray payload) are dropped
  efe_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .burst    (burst),
    .can_load (can_load),
    .line_ch  (line_ch)
  );

  // checksum byte always closes the run of its item
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    line_ch.valid && line_ch.frame_end |-> line_ch.run_last)
    else $error("frame end away from run end");

  // no run longer than the result register
  a_run_fits: assert property (@(posedge clk) disable iff (rst)
    accept |-> burst.cnt <= CntW'(MaxRun))
    else $error("byte run overflows result register");

  // an item that yields bytes shows its first byte next cycle
  a_run_shown: assert property (@(posedge clk) disable iff (rst)
    accept && burst.cnt != '0 |=> line_ch.valid)
    else $error("accepted run not presented");

  // back-pressure only while a run is pending
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ch.ready |-> line_ch.valid)
    else $error("input stalled with empty result register");

endmodule

// File: tb/sv/escaped_frame_encoder_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the escaped frame encoder: directed table, then random frames
module escaped_frame_encoder_tb;
  import efe_pkg::*;

  localparam int RandItems   = 96;      // random items that yield line bytes
  localparam int DirRows     = 23;
  localparam int NoLit       = -1;      // row checked against the frame predictor
  localparam int DrainCycles = 20;      // quiet spell after the last line byte
  localparam int LimitNs     = 200000;  // far beyond the slowest clean run
  localparam int PrintCap    = 200;     // keeps a broken build from flooding the log

  // one line byte as the receiver should see it
  typedef struct packed {
    logic [7:0] lbyte;
    logic       fend;
    logic       rlast;
  } line_exp_t;

  // directed row: item plus, where obvious, its line bytes typed in left to right
  typedef struct {
    req_t        item;
    int          n_lit;
    logic [47:0] lit;
    logic        lit_closes;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  efe_req_if  req_ch ();
  efe_line_if line_ch ();

  escaped_frame_encoder DUT (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .line_ch(line_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // frame predictor state, cleared as the block is by reset
  logic [7:0] frame_sum  = 8'd0;
  logic [7:0] bytes_due  = 8'd0;
  logic       frame_live = 1'b0;

  line_exp_t line_due [$];   // line bytes still owed by the block, oldest first
  int        err_cnt  = 0;
  int        src_calm = 0;   // items left in a no-gap stretch on the request side
  int        snk_calm = 0;   // same for the line side
  int        made_items = 0;

  dir_row_t dir_tab [DirRows] = '{
    // payload straight after reset: no frame open, nothing sent
    '{'{REQ_DATA,  8'h00, 8'h00, 8'h55}, 0, 48'h0,             1'b0},
    // empty frames: length byte 0x01 and the checksum at once
    '{'{REQ_START, 8'h00, 8'h00, 8'hA5}, 4, 48'h7E_01_00_FF_00_00, 1'b1},
    '{'{REQ_START, 8'hFF, 8'h00, 8'h00}, 4, 48'h7E_01_FF_00_00_00, 1'b1},
    // checksum of 0x7E goes out escaped
    '{'{REQ_START, 8'h81, 8'h00, 8'hFF}, 5, 48'h7E_01_81_7D_5E_00, 1'b1},
    // length 255 wraps the length byte to zero
    '{'{REQ_START, 8'h00, 8'hFF, 8'hFF}, 3, 48'h7E_00_00_00_00_00, 1'b0},
    // restart inside an open frame, length byte 0xFF
    '{'{REQ_START, 8'h55, 8'hFE, 8'h00}, 3, 48'h7E_FF_55_00_00_00, 1'b0},
    // length byte 0x7D escaped
    '{'{REQ_START, 8'h12, 8'h7C, 8'h00}, 4, 48'h7E_7D_5D_12_00_00, 1'b0},
    '{'{REQ_DATA,  8'hFF, 8'hFF, 8'h7E}, NoLit, 48'h0, 1'b0},
    // length bytes 0x11 and 0x13 escaped
    '{'{REQ_START, 8'h40, 8'h10, 8'h00}, 4, 48'h7E_7D_31_40_00_00, 1'b0},
    '{'{REQ_START, 8'h40, 8'h12, 8'hFF}, 4, 48'h7E_7D_33_40_00_00, 1'b0},
    // command byte goes out raw even when it is the flag
    '{'{REQ_START, 8'h7E, 8'h04, 8'h00}, 3, 48'h7E_05_7E_00_00_00, 1'b0},
    '{'{REQ_DATA,  8'hFF, 8'hFF, 8'h7D}, NoLit, 48'h0, 1'b0},
    '{'{REQ_DATA,  8'h00, 8'h00, 8'h11}, NoLit, 48'h0, 1'b0},
    '{'{REQ_DATA,  8'hFF, 8'h00, 8'h13}, NoLit, 48'h0, 1'b0},
    '{'{REQ_DATA,  8'h00, 8'hFF, 8'h00}, NoLit, 48'h0, 1'b0},
    // frame closed: stray payload ignored
    '{'{REQ_DATA,  8'hAA, 8'h01, 8'h42}, 0, 48'h0,             1'b0},
    // escaped payload followed by an escaped checksum
    '{'{REQ_START, 8'h03, 8'h01, 8'h00}, NoLit, 48'h0, 1'b0},
    '{'{REQ_DATA,  8'hFF, 8'hFF, 8'h7E}, NoLit, 48'h0, 1'b0},
    // length byte 0x7E escaped, then abandoned by the next start
    '{'{REQ_START, 8'h40, 8'h7D, 8'h00}, 4, 48'h7E_7D_5E_40_00_00, 1'b0},
    '{'{REQ_START, 8'hAA, 8'h02, 8'h00}, NoLit, 48'h0, 1'b0},
    '{'{REQ_DATA,  8'h00, 8'h00, 8'hFF}, NoLit, 48'h0, 1'b0},
    '{'{REQ_DATA,  8'hFF, 8'hFF, 8'h00}, NoLit, 48'h0, 1'b0},
    '{'{REQ_DATA,  8'h00, 8'h00, 8'hFF}, 0, 48'h0,             1'b0}
  };

  task automatic flag_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= PrintCap) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // idle cycles before the next item, with the odd stretch of none at all
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      calm = $urandom_range(4, 16);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // stuff one byte: the four reserved values go out as escape, byte xor 0x20
  function automatic void emit_esc(ref line_exp_t runq [$], input logic [7:0] b,
                                   input logic fend);
    if (b == FLAG_BYTE || b == ESC_BYTE || b == XON_BYTE || b == XOFF_BYTE) begin
      runq.push_back(line_exp_t'{ESC_BYTE, 1'b0, 1'b0});
      runq.push_back(line_exp_t'{b ^ ESC_XOR, fend, 1'b0});
    end else begin
      runq.push_back(line_exp_t'{b, fend, 1'b0});
    end
  endfunction

  // line bytes caused by one accepted item, advancing the frame state
  function automatic void encode_item(input req_t r, ref line_exp_t runq [$]);
    logic [7:0] len_plus;
    logic [7:0] chk;
    logic       close_now;
    line_exp_t  tail;
    close_now = 1'b0;
    if (r.req_type == REQ_START) begin
      len_plus = r.payload_length + 8'd1;
      runq.push_back(line_exp_t'{FLAG_BYTE, 1'b0, 1'b0});
      emit_esc(runq, len_plus, 1'b0);
      // command is never stuffed
      runq.push_back(line_exp_t'{r.command_code, 1'b0, 1'b0});
      frame_sum  = r.command_code;
      bytes_due  = r.payload_length;
      frame_live = 1'b1;
      close_now  = (r.payload_length == 8'd0);
    end else if (frame_live) begin
      emit_esc(runq, r.data_byte, 1'b0);
      frame_sum = frame_sum + r.data_byte;
      bytes_due = bytes_due - 8'd1;
      close_now = (bytes_due == 8'd0);
    end
    if (close_now) begin
      chk = SUM_BASE - frame_sum;
      emit_esc(runq, chk, 1'b1);
      frame_live = 1'b0;
      bytes_due  = 8'd0;
    end
    if (runq.size() > 0) begin
      tail = runq.pop_back();
      tail.rlast = 1'b1;
      runq.push_back(tail);
    end
  endfunction

  // payload bytes lean on the reserved values so stuffing is hit often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      2:       return XON_BYTE;
      3:       return XOFF_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic req_t start_item(input int len);
    req_t r;
    r.req_type       = REQ_START;
    r.command_code   = pick_byte();
    r.payload_length = 8'(len);
    r.data_byte      = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic req_t data_item();
    req_t r;
    r.req_type       = REQ_DATA;
    r.command_code   = 8'($urandom_range(0, 255));
    r.payload_length = 8'($urandom_range(0, 255));
    r.data_byte      = pick_byte();
    return r;
  endfunction

  // offer one item, wait for the handshake, then book the line bytes it owes
  task automatic issue(input req_t r, input int n_lit, input logic [47:0] lit,
                       input logic lit_closes);
    line_exp_t runq [$];
    int        gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= r.req_type;
    req_ch.command_code   <= r.command_code;
    req_ch.payload_length <= r.payload_length;
    req_ch.data_byte      <= r.data_byte;
    do @(posedge clk); while (!req_ch.ready);
    // predictor always runs so its frame state tracks typed-in rows too
    encode_item(r, runq);
    if (n_lit != NoLit) begin
      runq.delete();
      for (int i = 0; i < n_lit; i++) begin
        runq.push_back(line_exp_t'{lit[47 - 8*i -: 8], lit_closes && (i == n_lit - 1),
                                   i == n_lit - 1});
      end
    end
    if (runq.size() > 0) made_items++;
    foreach (runq[i]) line_due.push_back(runq[i]);
  endtask

  // receiver: random stalls ahead of every line byte
  initial begin
    int gap;
    line_ch.ready <= 1'b0;
    wait (!rst);
    forever begin
      gap = draw_gap(snk_calm);
      if (gap > 0) begin
        line_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      line_ch.ready <= 1'b1;
      do @(posedge clk); while (!line_ch.valid);
    end
  end

  // every accepted line byte against the oldest one owed
  always @(posedge clk) begin
    line_exp_t want;
    if (!rst && line_ch.valid && line_ch.ready) begin
      if (line_due.size() == 0) begin
        flag_mismatch($sformatf("line byte %02h with nothing owed", line_ch.line_byte));
      end else begin
        want = line_due.pop_front();
        if (line_ch.line_byte !== want.lbyte)
          flag_mismatch($sformatf("line_byte %02h, want %02h", line_ch.line_byte,
                                  want.lbyte));
        if (line_ch.frame_end !== want.fend)
          flag_mismatch($sformatf("frame_end %b, want %b on byte %02h", line_ch.frame_end,
                                  want.fend, want.lbyte));
        if (line_ch.run_last !== want.rlast)
          flag_mismatch($sformatf("run_last %b, want %b on byte %02h", line_ch.run_last,
                                  want.rlast, want.lbyte));
      end
    end
  end

  // stimulus: directed table, then frames of random shape and content
  initial begin
    int kind;
    int len;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_START;
    req_ch.command_code   <= 8'h00;
    req_ch.payload_length <= 8'h00;
    req_ch.data_byte      <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      issue(dir_tab[i].item, dir_tab[i].n_lit, dir_tab[i].lit, dir_tab[i].lit_closes);

    made_items = 0;
    while (made_items < RandItems) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // well-formed frame, mostly short, now and then a longer one
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        issue(start_item(len), NoLit, 48'h0, 1'b0);
        repeat (len) issue(data_item(), NoLit, 48'h0, 1'b0);
      end else if (kind <= 8) begin
        // any length, cut short by whatever comes next
        len = $urandom_range(0, 255);
        issue(start_item(len), NoLit, 48'h0, 1'b0);
        repeat ($urandom_range(0, 3)) issue(data_item(), NoLit, 48'h0, 1'b0);
      end else begin
        // stray payload, ignored when no frame is open
        repeat ($urandom_range(1, 2)) issue(data_item(), NoLit, 48'h0, 1'b0);
      end
    end
    req_ch.valid <= 1'b0;

    while (line_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("escaped_frame_encoder_tb: done, clean");
    end else begin
      $display("escaped_frame_encoder_tb: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #LimitNs;
    $display("escaped_frame_encoder_tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/efe_pkg.sv
rtl/efe_if.sv
rtl/efe_build.sv
rtl/efe_ser.sv
rtl/escaped_frame_encoder.sv
tb/sv/escaped_frame_encoder_tb.sv
